>>> sv/gap_framed_length_prefixed_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed deframer
// Shared concurrent assertion forms, clocked on clk_i with rst_ni as disable.
// ----------------------------------------------------------------------------
`ifndef GAP_FRAMED_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH
`define GAP_FRAMED_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define GFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define GFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gfd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Field widths and register addressing for the length-prefixed deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package gfd_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GapW   = 16;
  localparam int unsigned ApbW   = 32;
  localparam int unsigned AddrW  = 3;

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    REG_GAP_TICKS  = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [GapW-1:0]  GapTicksRst  = 16'd5;
  localparam logic [ByteW-1:0] MaxLengthRst = 8'd32;

endpackage : gfd_pkg

`default_nettype wire

>>> sv/gap_framed_length_prefixed_deframer_core.sv
// ----------------------------------------------------------------------------
// Gap-framed length-prefixed deframer core
// Splits a byte stream into frames by idle gaps and a length header byte.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word per item: mode_i = 0 is one elapsed tick,
// mode_i = 1 is a received byte on rx_byte_i. A byte that follows at least
// gap_ticks idle ticks is a length header (clamped to max_length) and makes no
// output. Later bytes up to that length leave on the output channel with
// their index; frame_last_o marks the final one and checksum_ok_o tells
// whether the XOR over the frame payload is zero. Extra bytes are dropped.
// out_valid_o is registered. One item is taken every cycle; the only limit is
// the single output register, so the input stalls exactly while a result is
// held and the receiver stalls. Reset empties the output register, saturates
// the idle counter so the first byte is a header, and loads gap_ticks = 5 and
// max_length = 32. The APB registers (gap_ticks at 0x0, max_length at 0x4)
// must be written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_framed_length_prefixed_deframer_core
  import gfd_pkg::*;
#(
  parameter int unsigned IDLE_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             mode_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  // Output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      payload_byte_o,
  output logic [ByteW-1:0]      byte_index_o,
  output logic                  frame_last_o,
  output logic                  checksum_ok_o,
  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]       prdata,
  output logic                  pready
);

  localparam int unsigned CmpW = (IDLE_BITS > GapW) ? IDLE_BITS : GapW;

  // Configuration registers
  logic [GapW-1:0]  gap_ticks_q;
  logic [ByteW-1:0] max_length_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q  <= GapTicksRst;
      max_length_q <= MaxLengthRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAP_TICKS:  gap_ticks_q  <= pwdata[GapW-1:0];
        REG_MAX_LENGTH: max_length_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_GAP_TICKS:  prdata = ApbW'(gap_ticks_q);
      REG_MAX_LENGTH: prdata = ApbW'(max_length_q);
      default:        prdata = '0;
    endcase
  end

  // Frame state and output register
  logic [IDLE_BITS-1:0] idle_count_q, idle_count_d;
  logic [ByteW-1:0]     expected_length_q, expected_length_d;
  logic [ByteW-1:0]     bytes_taken_q, bytes_taken_d;
  logic [ByteW-1:0]     running_xor_q, running_xor_d;
  logic                 out_valid_q, out_valid_d;
  logic [ByteW-1:0]     payload_byte_q, byte_index_q;
  logic                 frame_last_q, checksum_ok_q;

  logic             in_acc;
  logic             idle_sat;
  logic             header;
  logic             produce;
  logic [ByteW-1:0] bytes_next;
  logic [ByteW-1:0] xor_next;
  logic [ByteW-1:0] length_clamped;

  // The input waits only while a held result is being stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Header test: a saturated idle count always counts as a gap.
  assign idle_sat = &idle_count_q;
  assign header   = idle_sat || (CmpW'(idle_count_q) >= CmpW'(gap_ticks_q));

  assign produce        = mode_i && !header && (bytes_taken_q < expected_length_q);
  assign bytes_next     = bytes_taken_q + 1'b1;
  assign xor_next       = running_xor_q ^ rx_byte_i;
  assign length_clamped = (rx_byte_i > max_length_q) ? max_length_q : rx_byte_i;

  // Next frame state for one accepted word.
  always_comb begin
    idle_count_d      = idle_count_q;
    expected_length_d = expected_length_q;
    bytes_taken_d     = bytes_taken_q;
    running_xor_d     = running_xor_q;
    if (in_acc) begin
      if (!mode_i) begin
        if (!idle_sat) begin
          idle_count_d = idle_count_q + 1'b1;
        end
      end else begin
        idle_count_d = '0;
        if (header) begin
          expected_length_d = length_clamped;
          bytes_taken_d     = '0;
          running_xor_d     = '0;
        end else if (produce) begin
          bytes_taken_d = bytes_next;
          running_xor_d = xor_next;
        end
      end
    end
  end

  // Output valid: loaded on acceptance, else held while the receiver stalls.
  assign out_valid_d = in_acc ? produce : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_count_q      <= '1;
      expected_length_q <= '0;
      bytes_taken_q     <= '0;
      running_xor_q     <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      idle_count_q      <= idle_count_d;
      expected_length_q <= expected_length_d;
      bytes_taken_q     <= bytes_taken_d;
      running_xor_q     <= running_xor_d;
      out_valid_q       <= out_valid_d;
    end
  end

  // Result payload, loaded only when a payload byte is emitted.
  always_ff @(posedge clk_i) begin
    if (in_acc && produce) begin
      payload_byte_q <= rx_byte_i;
      byte_index_q   <= bytes_taken_q;
      frame_last_q   <= (bytes_next == expected_length_q);
      checksum_ok_q  <= (bytes_next == expected_length_q) && (xor_next == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = payload_byte_q;
  assign byte_index_o   = byte_index_q;
  assign frame_last_o   = frame_last_q;
  assign checksum_ok_o  = checksum_ok_q;

  // Assertions
`include "gap_framed_length_prefixed_deframer_core_macros.svh"

  `GFD_ASSERT_NOW(a_taken_le_len, 1'b1, bytes_taken_q <= expected_length_q, "count over length")
  `GFD_ASSERT_NOW(a_ok_on_last, out_valid_o && checksum_ok_o, frame_last_o, "ok without last")
  `GFD_ASSERT_NEXT(a_tick_no_out, in_acc && !mode_i, !out_valid_o, "tick produced a result")
  `GFD_ASSERT_NEXT(a_index_seq, in_acc && produce, byte_index_o == $past(bytes_taken_q), "index")

endmodule : gap_framed_length_prefixed_deframer_core

`default_nettype wire
